### sv/twr_pkg.sv
// ----------------------------------------------------------------------------
// twr_pkg
// shared types, constants and functions of the twister random generator
// ----------------------------------------------------------------------------
package twr_pkg;

  localparam int IDX_W = 10;
  localparam int WORD_W = 64;

  localparam logic [IDX_W-1:0] STATE_WORDS    = 10'd624;
  localparam logic [IDX_W-1:0] SHIFT_DISTANCE = 10'd397;
  localparam logic [IDX_W-1:0] LAST_IDX       = STATE_WORDS - 10'd1;
  localparam logic [IDX_W-1:0] WRAP_POINT     = STATE_WORDS - SHIFT_DISTANCE;

  localparam logic [31:0]       CHAIN_MULT  = 32'd2147001325;
  localparam logic [WORD_W-1:0] CHAIN_ADD   = 64'd715136305;
  localparam logic [WORD_W-1:0] CHAIN_XOR   = 64'h0000_0000_3141_5926;
  localparam logic [31:0]       UPPER_MASK  = 32'h8000_0000;
  localparam logic [31:0]       LOWER_MASK  = 32'h7fff_ffff;
  localparam logic [31:0]       MATRIX_A    = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] TEMPER_B    = 64'h0000_0000_9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C    = 64'h0000_0000_efc6_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_SUM,
    ST_SEED_WR,
    ST_TW_PRIME,
    ST_TW_LOAD,
    ST_TW_RD,
    ST_TW_WR,
    ST_RD_WORD,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic seed_start;
    logic seed_zero;
    logic seed_mul;
    logic seed_sum;
    logic seed_wr;
    logic tw_prime;
    logic tw_load;
    logic tw_rd;
    logic tw_wr;
    logic rd_word;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pos_full;
    logic seeded;
    logic idx_last;
  } status_t;

  // upper bit of one word, lower 31 bits of the next, then the matrix step
  function automatic logic [WORD_W-1:0] mix_pair(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
    logic [31:0] t;
    logic [31:0] m;
    t = (a[31:0] & UPPER_MASK) | (b[31:0] & LOWER_MASK);
    m = (t >> 1) ^ (t[0] ? MATRIX_A : 32'd0);
    return {32'd0, m};
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] w;
    w = x;
    w = w ^ (w >> 11);
    w = w ^ ((w << 7) & TEMPER_B);
    w = w ^ ((w << 15) & TEMPER_C);
    w = w ^ (w >> 18);
    return w;
  endfunction

  // sum of the word shifted right and left by 16 bits, then the fixed xor
  function automatic logic [WORD_W-1:0] chain_finish(input logic [WORD_W-1:0] s);
    logic [WORD_W-1:0] r;
    r = (s >> 16) + (s << 16);
    return CHAIN_XOR ^ r;
  endfunction

endpackage

### sv/twr_intf.sv
// ----------------------------------------------------------------------------
// twr channel interfaces
// valid/ready channels for request items and result items
// ----------------------------------------------------------------------------
interface twr_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] seed_value;

  modport source (output valid, output mode, output seed_value, input ready);
  modport sink (input valid, input mode, input seed_value, output ready);
endinterface

interface twr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink (input valid, input random_word, output ready);
endinterface

### sv/twr_dpath.sv
// ----------------------------------------------------------------------------
// twr_dpath
// word table memory, seed chain, twist step, tempering and output register
// ----------------------------------------------------------------------------
module twr_dpath
  import twr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic [WORD_W-1:0] seed_value,
  output status_t           status,
  output logic [WORD_W-1:0] random_word
);

  logic [WORD_W-1:0] mem [0:STATE_WORDS-1];

  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              seeded_r, seeded_nxt;
  logic [WORD_W-1:0] prev_r;
  logic [WORD_W-1:0] prod_lo_r;
  logic [31:0]       prod_hi_r;
  logic [WORD_W-1:0] sum_r;
  logic [WORD_W-1:0] cur_r;
  logic [WORD_W-1:0] rd_a_r;
  logic [WORD_W-1:0] rd_b_r;
  logic [WORD_W-1:0] out_r;

  logic [WORD_W-1:0] seed_word;
  logic [WORD_W-1:0] chain_word;
  logic [WORD_W-1:0] twist_word;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              rd_a_en;
  logic [IDX_W-1:0]  rd_a_addr;
  logic [IDX_W-1:0]  rd_b_addr;
  logic [IDX_W-1:0]  idx_wrap;
  logic              idx_last;

  assign idx_last   = (idx_r == LAST_IDX);
  assign idx_wrap   = idx_last ? '0 : idx_r + 10'd1;
  assign seed_word  = cmd.seed_zero ? '0 : seed_value;
  assign chain_word = chain_finish(sum_r);
  assign twist_word = rd_b_r ^ mix_pair(cur_r, rd_a_r);

  assign status.pos_full = (pos_r >= STATE_WORDS);
  assign status.seeded   = seeded_r;
  assign status.idx_last = idx_last;
  assign random_word     = out_r;

  // write port
  always_comb begin
    wr_en   = cmd.seed_start | cmd.seed_wr | cmd.tw_wr;
    wr_addr = cmd.seed_start ? '0 : idx_r;
    if (cmd.seed_start) begin
      wr_data = seed_word;
    end else if (cmd.seed_wr) begin
      wr_data = chain_word;
    end else begin
      wr_data = twist_word;
    end
  end

  // read ports: a serves next word and output reads, b the far source
  always_comb begin
    rd_a_en = cmd.tw_prime | cmd.tw_rd | cmd.rd_word;
    if (cmd.tw_prime) begin
      rd_a_addr = '0;
    end else if (cmd.tw_rd) begin
      rd_a_addr = idx_wrap;
    end else begin
      rd_a_addr = pos_r;
    end
    rd_b_addr = (idx_r < WRAP_POINT) ? idx_r + SHIFT_DISTANCE : idx_r - WRAP_POINT;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_a_en) begin
      rd_a_r <= mem[rd_a_addr];
    end
    if (cmd.tw_rd) begin
      rd_b_r <= mem[rd_b_addr];
    end
  end

  always_comb begin
    pos_nxt    = pos_r;
    idx_nxt    = idx_r;
    seeded_nxt = seeded_r;
    if (cmd.seed_start) begin
      pos_nxt    = STATE_WORDS;
      idx_nxt    = 10'd1;
      seeded_nxt = 1'b1;
    end
    if (cmd.seed_wr) begin
      idx_nxt = idx_r + 10'd1;
    end
    if (cmd.tw_prime) begin
      idx_nxt = '0;
    end
    if (cmd.tw_wr) begin
      idx_nxt = idx_wrap;
      if (idx_last) begin
        pos_nxt = '0;
      end
    end
    if (cmd.rd_word) begin
      pos_nxt = pos_r + 10'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= STATE_WORDS;
      idx_r    <= '0;
      seeded_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      idx_r    <= idx_nxt;
      seeded_r <= seeded_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.seed_start) begin
      prev_r <= seed_word;
    end else if (cmd.seed_wr) begin
      prev_r <= chain_word;
    end
    if (cmd.seed_mul) begin
      prod_lo_r <= {32'd0, prev_r[31:0]} * {32'd0, CHAIN_MULT};
      prod_hi_r <= prev_r[63:32] * CHAIN_MULT;
    end
    if (cmd.seed_sum) begin
      sum_r <= prod_lo_r + {prod_hi_r, 32'd0} + CHAIN_ADD;
    end
    if (cmd.tw_load | cmd.tw_wr) begin
      cur_r <= rd_a_r;
    end
    if (cmd.out_load) begin
      out_r <= temper(rd_a_r);
    end
  end

endmodule

### sv/twr_ctrl.sv
// ----------------------------------------------------------------------------
// twr_ctrl
// sequencer for requests, seed fill and twist pass
// ----------------------------------------------------------------------------
module twr_ctrl
  import twr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_mode,
  output logic    in_ready,
  input  logic    out_ready,
  output logic    out_valid,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   pend_r, pend_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode) begin
            cmd.seed_start = 1'b1;
            pend_nxt       = 1'b0;
            state_nxt      = ST_SEED_MUL;
          end else if (!status.pos_full) begin
            cmd.rd_word = 1'b1;
            state_nxt   = ST_OUT;
          end else if (!status.seeded) begin
            cmd.seed_start = 1'b1;
            cmd.seed_zero  = 1'b1;
            pend_nxt       = 1'b1;
            state_nxt      = ST_SEED_MUL;
          end else begin
            state_nxt = ST_TW_PRIME;
          end
        end
      end
      ST_SEED_MUL: begin
        cmd.seed_mul = 1'b1;
        state_nxt    = ST_SEED_SUM;
      end
      ST_SEED_SUM: begin
        cmd.seed_sum = 1'b1;
        state_nxt    = ST_SEED_WR;
      end
      ST_SEED_WR: begin
        cmd.seed_wr = 1'b1;
        if (status.idx_last) begin
          state_nxt = pend_r ? ST_TW_PRIME : ST_IDLE;
        end else begin
          state_nxt = ST_SEED_MUL;
        end
      end
      ST_TW_PRIME: begin
        cmd.tw_prime = 1'b1;
        state_nxt    = ST_TW_LOAD;
      end
      ST_TW_LOAD: begin
        cmd.tw_load = 1'b1;
        state_nxt   = ST_TW_RD;
      end
      ST_TW_RD: begin
        cmd.tw_rd = 1'b1;
        state_nxt = ST_TW_WR;
      end
      ST_TW_WR: begin
        cmd.tw_wr = 1'b1;
        state_nxt = status.idx_last ? ST_RD_WORD : ST_TW_RD;
      end
      ST_RD_WORD: begin
        cmd.rd_word = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

### sv/twister_random_generator.sv
// ----------------------------------------------------------------------------
// twister_random_generator
// 624 x 64-bit twister generator with reseed and tempered word output
// ----------------------------------------------------------------------------
// usage:
//   in_ch  : request items; mode 0 asks for the next word, mode 1 reseeds
//            the table with seed_value and gives no result
//   out_ch : one tempered 64-bit random_word per mode 0 item
// sequence:
//   a next-word item with words left in the table: read register, then
//   tempered into the output register; next item accepted after that load
//   table used up: a twist pass runs first (prime and load steps, then
//   read and write states for each word on the table memory)
//   reseed: word 0 written on acceptance, then each further word passes the
//   multiplier, adder and write stages of the dependent multiply-add chain
//   first next-word item after reset: seed with 0, then twist, then read
// reset:
//   table contents stay undefined, read position is set to used up and
//   the block is marked as not seeded; no clearing pass
// stall:
//   a result waits in the output register; the block holds the following
//   result in its read stage until the register is taken
// ----------------------------------------------------------------------------
module twister_random_generator
  import twr_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  twr_in_if.sink  in_ch,
  twr_out_if.source out_ch
);

  cmd_t              cmd;
  status_t           status;
  logic [WORD_W-1:0] word;

  // sequencer: request decode, seed fill loop, twist loop, output slot
  twr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .status    (status),
    .cmd       (cmd)
  );

  // table memory and the arithmetic around it
  twr_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .seed_value  (in_ch.seed_value),
    .status      (status),
    .random_word (word)
  );

  assign out_ch.random_word = word;

endmodule

### tb/twr_tb_pkg.sv
// ----------------------------------------------------------------------------
// twr_tb_pkg
// request codes shared by the generator test bench stimulus and checker
// ----------------------------------------------------------------------------
package twr_tb_pkg;

  typedef enum logic {
    MODE_NEXT   = 1'b0,
    MODE_RESEED = 1'b1
  } req_mode_t;

endpackage

### tb/twr_word_checker.sv
// ----------------------------------------------------------------------------
// twr_word_checker
// watches both channels, predicts each tempered word and compares in order
// ----------------------------------------------------------------------------
module twr_word_checker
  import twr_pkg::*;
  import twr_tb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  twr_in_if    in_ch,
  twr_out_if   out_ch,
  output int   fail_count,
  output int   pending,
  output int   checked_count
);

  localparam int N_WORDS = int'(STATE_WORDS);
  localparam int M_SHIFT = int'(SHIFT_DISTANCE);

  logic [WORD_W-1:0] word_tab [N_WORDS];
  int                read_pos;
  bit                seeded;
  logic [WORD_W-1:0] expected_words [$];

  function automatic logic [WORD_W-1:0] chain_step(input logic [WORD_W-1:0] p);
    logic [WORD_W-1:0] s;
    s = p * 64'd2147001325 + 64'd715136305;
    return 64'h0000_0000_3141_5926 ^ ((s >> 16) + (s << 16));
  endfunction

  function automatic logic [WORD_W-1:0] blend(input logic [WORD_W-1:0] a,
                                              input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] t;
    t = (a & 64'h0000_0000_8000_0000) | (b & 64'h0000_0000_7fff_ffff);
    return (t >> 1) ^ (t[0] ? 64'h0000_0000_9908_b0df : 64'd0);
  endfunction

  function automatic logic [WORD_W-1:0] tempered(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] w;
    w = x;
    w = w ^ (w >> 11);
    w = w ^ ((w << 7) & 64'h0000_0000_9d2c_5680);
    w = w ^ ((w << 15) & 64'h0000_0000_efc6_0000);
    w = w ^ (w >> 18);
    return w;
  endfunction

  task automatic fill_from_seed(input logic [WORD_W-1:0] seed);
    word_tab[0] = seed;
    for (int i = 1; i < N_WORDS; i++) word_tab[i] = chain_step(word_tab[i-1]);
    read_pos = N_WORDS;
    seeded   = 1'b1;
  endtask

  task automatic twist_words();
    logic [WORD_W-1:0] t;
    int                src;
    for (int i = 0; i < N_WORDS - 1; i++) begin
      t   = blend(word_tab[i], word_tab[i+1]);
      src = i + M_SHIFT;
      if (src >= N_WORDS) src -= N_WORDS;
      word_tab[i] = word_tab[src] ^ t;
    end
    word_tab[N_WORDS-1] = word_tab[M_SHIFT-1] ^ blend(word_tab[N_WORDS-1], word_tab[0]);
  endtask

  // next word the generator should hand out
  task automatic draw_word(output logic [WORD_W-1:0] w);
    if (read_pos >= N_WORDS) begin
      if (!seeded) fill_from_seed('0);
      twist_words();
      read_pos = 0;
    end
    w = tempered(word_tab[read_pos]);
    read_pos++;
  endtask

  always @(posedge clk) begin
    logic [WORD_W-1:0] w;
    if (!rst_n) begin
      read_pos      = N_WORDS;
      seeded        = 1'b0;
      expected_words.delete();
      fail_count    <= 0;
      checked_count <= 0;
      pending       <= 0;
    end else begin
      // results first, so a stray one never matches a fresh prediction
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          $error("random_word with nothing expected: actual %h", out_ch.random_word);
          fail_count <= fail_count + 1;
        end else begin
          w = expected_words.pop_front();
          if (out_ch.random_word !== w) begin
            $error("random_word mismatch: expected %h, actual %h", w, out_ch.random_word);
            fail_count <= fail_count + 1;
          end
          checked_count <= checked_count + 1;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.mode == MODE_RESEED) begin
          fill_from_seed(in_ch.seed_value);
        end else begin
          draw_word(w);
          expected_words.push_back(w);
        end
      end
      pending <= expected_words.size();
    end
  end

endmodule

### tb/tb_twister_random_generator.sv
// ----------------------------------------------------------------------------
// tb_twister_random_generator
// drives reseed and next-word requests with random gaps and output stalls;
// a checker beside the block predicts every word and reports failures
// ----------------------------------------------------------------------------
module tb_twister_random_generator;
  import twr_pkg::*;
  import twr_tb_pkg::*;

  // generous watchdog, far beyond the slowest legal run
  localparam int CYCLE_LIMIT = 1_000_000;
  // one reseed plus one twist pass, with margin
  localparam int TAIL_CYCLES = 3_500;
  localparam int RAND_ITEMS  = 850;

  logic clk;
  logic rst_n;
  int   cycles = 0;
  int   fail_count;
  int   pending;
  int   checked_count;
  int   n_next;
  int   n_reseed;
  bit   steady;

  twr_in_if  in_ch ();
  twr_out_if out_ch ();

  twister_random_generator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  twr_word_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count)
  );

  // free-running clock, 20 units per period
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  // watchdog: a hung handshake ends the run here
  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("FAIL twister_random_generator");
    $finish;
  end

  // result side: ready low about 30 percent of the time, never while steady
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 30);
    end
  end

  // one request item; waits for the accepting edge
  task automatic push_request(input req_mode_t m, input logic [WORD_W-1:0] seed);
    int gap;
    if (!steady && $urandom_range(99) < 30) begin
      gap = $urandom_range(2, 1);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= m;
    in_ch.seed_value <= seed;
    do @(posedge clk); while (!in_ch.ready);
    if (m == MODE_RESEED) n_reseed++;
    else n_next++;
  endtask

  // hold off the sender until every expected word is back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [WORD_W-1:0] pick_seed();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  initial begin
    req_mode_t m;
    bit        no_reseed;

    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_NEXT;
    in_ch.seed_value = '0;
    rst_n            = 1'b0;
    steady           = 1'b0;
    n_next           = 0;
    n_reseed         = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    // first request before any seed: implicit seed with 0, twist, word 0
    push_request(MODE_NEXT, '0);
    push_request(MODE_NEXT, '1);                   // seed field ignored on next
    push_request(MODE_RESEED, '0);
    push_request(MODE_NEXT, '0);
    push_request(MODE_NEXT, 64'h1234_5678_9abc_def0);
    push_request(MODE_RESEED, '1);
    push_request(MODE_NEXT, '0);
    push_request(MODE_NEXT, '0);
    // back-to-back reseeds, only the last one counts
    push_request(MODE_RESEED, 64'd1);
    push_request(MODE_RESEED, 64'h8000_0000_0000_0000);
    push_request(MODE_NEXT, '0);
    push_request(MODE_RESEED, 64'h5555_5555_5555_5555);
    push_request(MODE_NEXT, '1);
    push_request(MODE_RESEED, 64'haaaa_aaaa_aaaa_aaaa);
    push_request(MODE_NEXT, '0);
    push_request(MODE_NEXT, '0);
    // reseed while a word may still wait in the output register
    push_request(MODE_RESEED, 64'h0000_0000_ffff_ffff);
    push_request(MODE_NEXT, '0);
    drain_results();

    // random part
    // a long run of next items with no reseed crosses the natural
    // table wrap at least once; outside it reseeds are rare
    for (int i = 0; i < RAND_ITEMS; i++) begin
      no_reseed = (i >= 80) && (i < 760);
      steady    <= (i >= 300) && (i < 450);
      if (i == 500) drain_results();
      m = (!no_reseed && $urandom_range(47) == 0) ? MODE_RESEED : MODE_NEXT;
      push_request(m, pick_seed());
    end
    in_ch.valid <= 1'b0;
    steady      <= 1'b0;

    // all accepted: wait for the last word, then a quiet tail
    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d next-word and %0d reseed requests", n_next, n_reseed);
    $display("%0d words checked, %0d failures", checked_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS twister_random_generator");
    end else begin
      $display("FAIL twister_random_generator");
    end
    $finish;
  end

endmodule
